// ===== src/bdq_pkg.sv =====
package bdq_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [VALUE_W-1:0]  word_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_SEARCH     = 3'd4;
    localparam op_t OP_CLEAR      = 3'd5;

    localparam status_t STATUS_DONE      = 3'd0;
    localparam status_t STATUS_EMPTY     = 3'd1;
    localparam status_t STATUS_FULL      = 3'd2;
    localparam status_t STATUS_FOUND     = 3'd3;
    localparam status_t STATUS_NOT_FOUND = 3'd4;

endpackage

// ===== src/bdq_ring_add.sv =====
module bdq_ring_add #(
    parameter int DEPTH = 64
) (
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] base,
    input  logic [$clog2(DEPTH + 1)-1:0]                 offset,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pos
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_S = (CW + 1)'(DEPTH);

    logic [CW:0] total;
    logic [CW:0] wrapped;

    assign total   = (CW + 1)'(base) + (CW + 1)'(offset);
    assign wrapped = (total >= DEPTH_S) ? (total - DEPTH_S) : total;
    assign pos     = wrapped[AW-1:0];

endmodule

// ===== src/bounded_deque_with_search.sv =====
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall   op, value
// output    out        out_valid/out_stall status, count
//
// Push, pop, clear and unused codes: result registered in the cycle after acceptance.
// Search over n stored entries: one entry memory read per cycle, each compared with the
// key once its registered read data returns; an empty store answers without a scan.
// Reset clears the pointers, count and state; the entry memory is not cleared.
// in_stall is high during a search and while a result waits under out_stall.
module bounded_deque_with_search #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bdq_pkg::OP_W-1:0]         op,
    input  logic signed [bdq_pkg::VALUE_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bdq_pkg::STATUS_W-1:0]     status,
    output logic [$clog2(DEPTH + 1)-1:0]     count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [AW-1:0]          front_reg, front_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          offset_reg, offset_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   rd_last_reg, rd_last_next;
    logic                   out_valid_reg, out_valid_next;
    bdq_pkg::word_t         key_reg, key_next;
    bdq_pkg::status_t       res_reg, res_next;
    bdq_pkg::status_t       out_status_reg;
    logic [CW-1:0]          out_count_reg;
    bdq_pkg::word_t         rd_data_reg;

    bdq_pkg::word_t         mem [DEPTH];

    logic                   in_accept;
    logic                   out_free;
    logic                   is_full;
    logic                   is_empty;
    logic                   load;
    bdq_pkg::status_t       load_status;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          back_pos;
    logic [AW-1:0]          scan_pos;
    logic [AW-1:0]          front_dec;
    logic [AW-1:0]          front_inc;

    bdq_ring_add #(.DEPTH(DEPTH)) u_back_pos (
        .base   (front_reg),
        .offset (count_reg),
        .pos    (back_pos)
    );

    bdq_ring_add #(.DEPTH(DEPTH)) u_scan_pos (
        .base   (front_reg),
        .offset (offset_reg),
        .pos    (scan_pos)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign is_full   = (count_reg == DEPTH_C);
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_IDX : (front_reg - AW'(1));
    assign front_inc = (front_reg == LAST_IDX) ? '0 : (front_reg + AW'(1));

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_addr      = back_pos;
        rd_en        = 1'b0;
        rd_vld_next  = 1'b0;
        rd_last_next = 1'b0;
        load         = 1'b0;
        load_status  = bdq_pkg::STATUS_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    load = 1'b1;
                    unique case (op)
                        bdq_pkg::OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                load_status = bdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                front_next = front_dec;
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                load_status = bdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = back_pos;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                load_status = bdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        bdq_pkg::OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                load_status = bdq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        bdq_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                load_status = bdq_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                load        = 1'b0;
                                key_next    = value;
                                offset_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        bdq_pkg::OP_CLEAR:
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (rd_vld_reg && (rd_data_reg == key_reg))
                begin
                    res_next   = bdq_pkg::STATUS_FOUND;
                    state_next = S_FINISH;
                end
                else if (rd_vld_reg && rd_last_reg)
                begin
                    res_next   = bdq_pkg::STATUS_NOT_FOUND;
                    state_next = S_FINISH;
                end
                else if (offset_reg != count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_last_next = (offset_reg == (count_reg - CW'(1)));
                    offset_next  = offset_reg + CW'(1);
                end
                else
                begin
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_status = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            rd_vld_reg    <= rd_vld_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        res_reg <= res_next;
        if (load)
        begin
            out_status_reg <= load_status;
            out_count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_pos];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("entry count above depth");

    assert property (@(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> !wr_en)
        else $error("entry write during search");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> ($stable(front_reg) && $stable(count_reg)))
        else $error("ring pointers moved during search");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !rd_vld_reg)
        else $error("read data pending after search end");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH       = 64;
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS  = 900;
    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 37;

    localparam bdq_pkg::op_t OP_SPARE_6 = 3'd6;
    localparam bdq_pkg::op_t OP_SPARE_7 = 3'd7;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        bdq_pkg::status_t status;
        count_t           count;
    } reply_t;

    class deque_shadow;
        bdq_pkg::word_t slots [DEPTH];
        int unsigned    head;
        int unsigned    fill;
        reply_t         awaited [$];
        int             mismatches;
        int             status_hits [8];

        function new();
            head       = 0;
            fill       = 0;
            mismatches = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function bdq_pkg::word_t stored_at(int unsigned k);
            return slots[(head + k) % DEPTH];
        endfunction

        function void note_request(bdq_pkg::op_t o, bdq_pkg::word_t v);
            reply_t r;
            r.status = bdq_pkg::STATUS_DONE;
            case (o)
                bdq_pkg::OP_PUSH_FRONT:
                    if (fill >= DEPTH) r.status = bdq_pkg::STATUS_FULL;
                    else
                    begin
                        head        = (head + DEPTH - 1) % DEPTH;
                        slots[head] = v;
                        fill++;
                    end
                bdq_pkg::OP_PUSH_BACK:
                    if (fill >= DEPTH) r.status = bdq_pkg::STATUS_FULL;
                    else
                    begin
                        slots[(head + fill) % DEPTH] = v;
                        fill++;
                    end
                bdq_pkg::OP_POP_FRONT:
                    if (fill == 0) r.status = bdq_pkg::STATUS_EMPTY;
                    else
                    begin
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                bdq_pkg::OP_POP_BACK:
                    if (fill == 0) r.status = bdq_pkg::STATUS_EMPTY;
                    else fill--;
                bdq_pkg::OP_SEARCH:
                begin
                    r.status = bdq_pkg::STATUS_NOT_FOUND;
                    for (int unsigned k = 0; k < fill; k++)
                    begin
                        if (stored_at(k) == v)
                        begin
                            r.status = bdq_pkg::STATUS_FOUND;
                            break;
                        end
                    end
                end
                bdq_pkg::OP_CLEAR:
                begin
                    head = 0;
                    fill = 0;
                end
                default: ;
            endcase
            r.count = count_t'(fill);
            status_hits[r.status]++;
            awaited.push_back(r);
        endfunction

        function void check_reply(bdq_pkg::status_t s, count_t c);
            reply_t r;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: status %0d, count %0d", s, c);
                mismatches++;
                return;
            end
            r = awaited.pop_front();
            if (s !== r.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", r.status, s);
                mismatches++;
            end
            if (c !== r.count)
            begin
                $error("count mismatch: expected %0d, actual %0d", r.count, c);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    bdq_pkg::op_t     op = bdq_pkg::OP_PUSH_FRONT;
    bdq_pkg::word_t   value = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    bdq_pkg::status_t status;
    count_t           count;

    logic        steady = 1'b0;
    int unsigned quiet = 0;
    deque_shadow shadow = new();

    bounded_deque_with_search #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .value    (value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .count    (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall) shadow.check_reply(status, count);
            if (in_valid && !in_stall) shadow.note_request(op, value);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic send_item(input bdq_pkg::op_t o, input bdq_pkg::word_t v);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        @(negedge clk);
        while (shadow.awaited.size() != 0) @(negedge clk);
    endtask

    function automatic bdq_pkg::word_t pick_push_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom;
        if (roll < 70)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return bdq_pkg::word_t'($urandom_range(0, 15));
    endfunction

    function automatic bdq_pkg::word_t pick_search_value();
        int unsigned    roll;
        bdq_pkg::word_t hit;
        roll = $urandom_range(0, 99);
        if (shadow.fill == 0 || roll >= 80) return pick_push_value();
        hit = shadow.stored_at($urandom_range(0, shadow.fill - 1));
        if (roll < 60) return hit;
        return hit ^ (bdq_pkg::word_t'(1) << $urandom_range(0, 31));
    endfunction

    task automatic run_directed();
        send_item(bdq_pkg::OP_SEARCH, 32'h0000_0000);
        send_item(bdq_pkg::OP_POP_FRONT, $urandom);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(OP_SPARE_6, $urandom);
        send_item(OP_SPARE_7, $urandom);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(bdq_pkg::OP_PUSH_BACK, 32'h8000_0000);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        send_item(bdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_item(bdq_pkg::OP_SEARCH, 32'h8000_0000);
        send_item(bdq_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_item(bdq_pkg::OP_SEARCH, 32'h0000_0001);
        send_item(bdq_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_item(bdq_pkg::OP_SEARCH, 32'h7FFF_FFFE);
        send_item(bdq_pkg::OP_POP_FRONT, $urandom);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_SEARCH, 32'h0000_0000);
        send_item(bdq_pkg::OP_CLEAR, $urandom);
        send_item(bdq_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
        send_item(bdq_pkg::OP_PUSH_BACK, 32'h1234_5678);
        send_item(bdq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
        send_item(bdq_pkg::OP_SEARCH, 32'h1234_5678);
        send_item(bdq_pkg::OP_POP_FRONT, $urandom);
        send_item(bdq_pkg::OP_POP_BACK, $urandom);
    endtask

    task automatic run_random();
        int unsigned  mode;
        int unsigned  left;
        int unsigned  roll;
        int unsigned  push_pct;
        int unsigned  pop_pct;
        bdq_pkg::op_t o;
        left = 0;
        mode = 0;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS / 2) wait_for_replies();
            steady = (n >= 200 && n < 350);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(60, 140);
            end
            left--;
            case (mode)
                0:       begin push_pct = 85; pop_pct = 10; end
                1:       begin push_pct = 15; pop_pct = 70; end
                default: begin push_pct = 35; pop_pct = 30; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 2)
                o = bdq_pkg::OP_CLEAR;
            else if (roll < 4)
                o = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            else if (roll < 4 + push_pct)
                o = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
            else if (roll < 4 + push_pct + pop_pct)
                o = $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
            else
                o = bdq_pkg::OP_SEARCH;
            if (o == bdq_pkg::OP_SEARCH) send_item(o, pick_search_value());
            else send_item(o, pick_push_value());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        wait_for_replies();
        run_random();
        wait_for_replies();
        repeat (80) @(posedge clk);
        $display("Ran %0d transactions: %0d done, %0d full drops, %0d empty pops,",
                 shadow.status_hits[bdq_pkg::STATUS_DONE]
                 + shadow.status_hits[bdq_pkg::STATUS_FULL]
                 + shadow.status_hits[bdq_pkg::STATUS_EMPTY]
                 + shadow.status_hits[bdq_pkg::STATUS_FOUND]
                 + shadow.status_hits[bdq_pkg::STATUS_NOT_FOUND],
                 shadow.status_hits[bdq_pkg::STATUS_DONE],
                 shadow.status_hits[bdq_pkg::STATUS_FULL],
                 shadow.status_hits[bdq_pkg::STATUS_EMPTY]);
        $display("  %0d searches hit and %0d missed, with stalls on both channels.",
                 shadow.status_hits[bdq_pkg::STATUS_FOUND],
                 shadow.status_hits[bdq_pkg::STATUS_NOT_FOUND]);
        if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
